>>> hdl/assert_macros.svh
// Assertion macros used by the queue back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define CQF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cqf assertion failed");
// Checked on every rising clock edge, reset included.
`define CQF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cqf assertion failed");
`else
`define CQF_ASSERT(lbl, clk, rst_n, prop)
`define CQF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hdl/cqf_pkg.sv
// Shared types, codes and sizes of the circular queue block.
package cqf_pkg;

    localparam int DATA_W    = 32;
    localparam int CAP_W     = 5;
    localparam int DEPTH_DEF = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Small decoupling queues
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    // Request action codes
    localparam logic [1:0] ACT_SHOW   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    // Internal operation codes
    localparam logic [1:0] OP_SHOW   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DELETED  = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_SHOWN    = 3'd4;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

endpackage

>>> hdl/cqf_fifo.sv
// Small register-based FIFO used for the command and result queues.
module cqf_fifo #(
    parameter int WIDTH = 8,
    parameter int FD    = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(FD+1)-1:0]    o_count
);

    localparam int AW = (FD > 1) ? $clog2(FD) : 1;
    localparam int CW = $clog2(FD + 1);

    logic [WIDTH-1:0] r_slot [FD];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(FD));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(FD - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(FD - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

>>> hdl/cqf_front.sv
// Front end: accepts requests, classifies the action, queues commands.
module cqf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cqf_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_cmd_pop,
    output logic              o_cmd_valid,
    output cqf_pkg::t_cmd     o_cmd
);

    cqf_pkg::t_cmd cmd_in;
    logic          keep;
    logic          cmd_empty;
    logic [$clog2(cqf_pkg::CMD_DEPTH + 1)-1:0] cmd_count;

    // decode: unknown actions are swallowed without a result
    always_comb begin
        keep         = 1'b1;
        cmd_in.op    = cqf_pkg::OP_SHOW;
        cmd_in.value = '0;
        case (i_item.action)
            cqf_pkg::ACT_SHOW: begin
                cmd_in.op = cqf_pkg::OP_SHOW;
            end
            cqf_pkg::ACT_INSERT: begin
                cmd_in.op    = cqf_pkg::OP_INSERT;
                cmd_in.value = i_item.value;
            end
            cqf_pkg::ACT_DELETE: begin
                cmd_in.op = cqf_pkg::OP_DELETE;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    cqf_fifo #(
        .WIDTH ($bits(cqf_pkg::t_cmd)),
        .FD    (cqf_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_data  (cmd_in),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_full  (o_full),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    assign o_cmd_valid = !cmd_empty && (cmd_count != '0);

endmodule

>>> hdl/cqf_back.sv
// Back end: queue storage, front/rear indices, display walker, result stage.
`include "assert_macros.svh"

module cqf_back #(
    parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_last_idx,
    input  logic                                  i_clear,
    input  logic                                  i_cmd_valid,
    input  cqf_pkg::t_cmd                         i_cmd,
    output logic                                  o_cmd_pop,
    input  logic [cqf_pkg::RES_CW-1:0]            i_res_count,
    output logic                                  o_res_push,
    output cqf_pkg::t_out_item                    o_res
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = cqf_pkg::RES_CW;

    localparam logic S_RUN  = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic signed [cqf_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [cqf_pkg::DATA_W-1:0] r_rd_data;

    logic [IW-1:0] r_front, n_front;
    logic [IW-1:0] r_rear,  n_rear;
    logic [IW-1:0] r_walk,  n_walk;
    logic          r_is_empty, n_is_empty;
    logic          r_state, n_state;

    logic          r_s2_valid, n_s2_valid;
    logic [2:0]    r_s2_status, n_s2_status;
    logic          r_s2_last, n_s2_last;
    logic          r_s2_mem, n_s2_mem;

    logic          go;
    logic          we;
    logic [IW-1:0] wa;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] walk_idx;
    logic [IW-1:0] rear_adv;
    logic [IW-1:0] front_adv;
    logic [IW-1:0] walk_adv;

    function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx,
                                          input logic [IW-1:0] last_idx);
        adv = (idx == last_idx) ? '0 : idx + IW'(1);
    endfunction

    // result queue room, counting the word already in the result stage
    assign go = i_cmd_valid &&
                (({1'b0, i_res_count} + (CW + 1)'(r_s2_valid)) < (CW + 1)'(cqf_pkg::RES_DEPTH));

    assign walk_idx  = (r_state == S_WALK) ? r_walk : r_front;
    assign rear_adv  = adv(r_rear, i_last_idx);
    assign front_adv = adv(r_front, i_last_idx);
    assign walk_adv  = adv(walk_idx, i_last_idx);

    // execute one command step
    always_comb begin
        n_front     = r_front;
        n_rear      = r_rear;
        n_walk      = r_walk;
        n_is_empty  = r_is_empty;
        n_state     = r_state;
        n_s2_valid  = 1'b0;
        n_s2_status = cqf_pkg::ST_INSERTED;
        n_s2_last   = 1'b1;
        n_s2_mem    = 1'b0;
        o_cmd_pop   = 1'b0;
        we          = 1'b0;
        wa          = '0;
        rd_addr     = r_front;

        if (i_clear) begin
            n_front    = '0;
            n_rear     = '0;
            n_is_empty = 1'b1;
            n_state    = S_RUN;
        end else if (go) begin
            n_s2_valid = 1'b1;
            case (i_cmd.op)
                cqf_pkg::OP_INSERT: begin
                    o_cmd_pop = 1'b1;
                    if (r_is_empty) begin
                        we         = 1'b1;
                        wa         = '0;
                        n_front    = '0;
                        n_rear     = '0;
                        n_is_empty = 1'b0;
                    end else if (rear_adv == r_front) begin
                        n_s2_status = cqf_pkg::ST_FULL;
                    end else begin
                        we     = 1'b1;
                        wa     = rear_adv;
                        n_rear = rear_adv;
                    end
                end
                cqf_pkg::OP_DELETE: begin
                    o_cmd_pop = 1'b1;
                    if (r_is_empty) begin
                        n_s2_status = cqf_pkg::ST_EMPTY;
                    end else begin
                        n_s2_status = cqf_pkg::ST_DELETED;
                        n_s2_mem    = 1'b1;
                        rd_addr     = r_front;
                        if (r_front == r_rear) begin
                            n_front    = '0;
                            n_rear     = '0;
                            n_is_empty = 1'b1;
                        end else begin
                            n_front = front_adv;
                        end
                    end
                end
                cqf_pkg::OP_SHOW: begin
                    if (r_is_empty) begin
                        o_cmd_pop   = 1'b1;
                        n_s2_status = cqf_pkg::ST_EMPTY;
                    end else begin
                        n_s2_status = cqf_pkg::ST_SHOWN;
                        n_s2_mem    = 1'b1;
                        rd_addr     = walk_idx;
                        if (walk_idx == r_rear) begin
                            o_cmd_pop = 1'b1;
                            n_state   = S_RUN;
                        end else begin
                            n_s2_last = 1'b0;
                            n_walk    = walk_adv;
                            n_state   = S_WALK;
                        end
                    end
                end
                default: begin
                    o_cmd_pop  = 1'b1;
                    n_s2_valid = 1'b0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_rear     <= '0;
            r_walk     <= '0;
            r_is_empty <= 1'b1;
            r_state    <= S_RUN;
            r_s2_valid <= 1'b0;
        end else begin
            r_front    <= n_front;
            r_rear     <= n_rear;
            r_walk     <= n_walk;
            r_is_empty <= n_is_empty;
            r_state    <= n_state;
            r_s2_valid <= n_s2_valid;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        r_s2_status <= n_s2_status;
        r_s2_last   <= n_s2_last;
        r_s2_mem    <= n_s2_mem;
    end

    // queue storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_s2_mem) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_res_push    = r_s2_valid;
    assign o_res.status  = r_s2_status;
    assign o_res.data    = r_s2_mem ? r_rd_data : '0;
    assign o_res.last    = r_s2_last;

    `CQF_ASSERT(a_empty_idx_zero, i_clk, i_rst_n, r_is_empty |-> (r_front == '0 && r_rear == '0))
    `CQF_ASSERT(a_idx_in_cap, i_clk, i_rst_n, (r_front <= i_last_idx) && (r_rear <= i_last_idx))
    `CQF_ASSERT(a_walk_not_empty, i_clk, i_rst_n, (r_state == S_WALK) |-> !r_is_empty)
    `CQF_ASSERT(a_res_room, i_clk, i_rst_n, r_s2_valid |-> (i_res_count < CW'(cqf_pkg::RES_DEPTH)))

endmodule

>>> hdl/circular_queue_fifo.sv
// Circular queue of signed 32-bit words driven by insert, delete and display
// requests. A request is taken when push is high and full is low; results are
// read like a queue through empty and pop, one result per pop. Insert and
// delete each give one result and, with results being popped, run at one
// request per cycle; a result passes through the command queue, the execute
// step into the result register and the result queue before it is on the
// result ports.
// Display walks the stored words through the single read port of the word
// store, one word per cycle while the result queue has room, and holds the
// execute step until the last stored word is read (a single result when the
// queue is empty) while later requests wait in the command queue. Writing the
// capacity register empties the queue; a capacity of zero acts as one and
// values above DEPTH act as DEPTH. Write the capacity only while no request is in flight.
module circular_queue_fifo #(
    parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    input  cqf_pkg::t_in_item           i_item,
    output logic                        full,
    output logic                        empty,
    input  logic                        pop,
    output cqf_pkg::t_out_item          o_result,
    input  logic                        i_cfg_we,
    input  logic [cqf_pkg::CAP_W-1:0]   i_cfg_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (cqf_pkg::CAP_W > IW + 1) ? cqf_pkg::CAP_W : IW + 1;

    logic [cqf_pkg::CAP_W-1:0] r_cap;
    logic [XW-1:0]             cap_x;
    logic [IW-1:0]             last_idx;

    logic                      cmd_valid;
    logic                      cmd_pop;
    cqf_pkg::t_cmd             cmd;
    logic                      res_push;
    cqf_pkg::t_out_item        res;
    logic                      res_full;
    logic [cqf_pkg::RES_CW-1:0] res_count;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= cqf_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // highest index in use, capacity clamped to 1..DEPTH
    assign cap_x = XW'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            last_idx = '0;
        end else if (cap_x > XW'(DEPTH)) begin
            last_idx = IW'(DEPTH - 1);
        end else begin
            last_idx = IW'(cap_x - XW'(1));
        end
    end

    cqf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    cqf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_last_idx  (last_idx),
        .i_clear     (i_cfg_we),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    cqf_fifo #(
        .WIDTH ($bits(cqf_pkg::t_out_item)),
        .FD    (cqf_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push && !res_full),
        .i_data  (res),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_full  (res_full),
        .o_empty (empty),
        .o_count (res_count)
    );

endmodule

>>> dv/circular_queue_fifo_checker.sv
// Checker for the circular queue: tracks requests and results and compares them.
module circular_queue_fifo_checker #(
    parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_full,
    input  cqf_pkg::t_in_item           i_item,
    input  logic                        i_empty,
    input  logic                        i_pop,
    input  cqf_pkg::t_out_item          i_result,
    input  logic                        i_cfg_we,
    input  logic [cqf_pkg::CAP_W-1:0]   i_cfg_data,
    output int                          o_fails,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the queue
    logic signed [cqf_pkg::DATA_W-1:0] words [DEPTH];
    int                                head;
    int                                tail;
    bit                                drained;
    logic [cqf_pkg::CAP_W-1:0]         cap_reg;

    // Results still owed by the block, oldest first
    cqf_pkg::t_out_item answers_due [$];

    // Slots in use: zero acts as one, anything above DEPTH as DEPTH
    function automatic int slots();
        if (cap_reg == '0) begin
            return 1;
        end
        if (int'(cap_reg) > DEPTH) begin
            return DEPTH;
        end
        return int'(cap_reg);
    endfunction

    function automatic int next_slot(input int idx);
        return (idx + 1 >= slots()) ? 0 : idx + 1;
    endfunction

    function automatic void owe(input logic [2:0] status,
                                input logic signed [cqf_pkg::DATA_W-1:0] data,
                                input logic last);
        cqf_pkg::t_out_item res;
        res.status = status;
        res.data   = data;
        res.last   = last;
        answers_due.push_back(res);
    endfunction

    task automatic report(input string msg);
        $display("[%0t] queue mismatch: %s", $time, msg);
        o_fails++;
    endtask

    // Work out the results of one request and update the shadow queue
    task automatic serve_request(input cqf_pkg::t_in_item req);
        int lim;
        int idx;
        int n;
        lim  = slots();
        head = head % lim;
        tail = tail % lim;
        case (req.action)
            cqf_pkg::ACT_INSERT: begin
                if (drained) begin
                    head     = 0;
                    tail     = 0;
                    words[0] = req.value;
                    drained  = 1'b0;
                    owe(cqf_pkg::ST_INSERTED, '0, 1'b1);
                end else if (next_slot(tail) == head) begin
                    owe(cqf_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    tail        = next_slot(tail);
                    words[tail] = req.value;
                    owe(cqf_pkg::ST_INSERTED, '0, 1'b1);
                end
            end
            cqf_pkg::ACT_DELETE: begin
                if (drained) begin
                    owe(cqf_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    owe(cqf_pkg::ST_DELETED, words[head], 1'b1);
                    // last word out puts the queue back to its empty state
                    if (head == tail) begin
                        head    = 0;
                        tail    = 0;
                        drained = 1'b1;
                    end else begin
                        head = next_slot(head);
                    end
                end
            end
            cqf_pkg::ACT_SHOW: begin
                if (drained) begin
                    owe(cqf_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    idx = head;
                    n   = 0;
                    while (idx != tail && n < DEPTH - 1) begin
                        owe(cqf_pkg::ST_SHOWN, words[idx], 1'b0);
                        n++;
                        idx = next_slot(idx);
                    end
                    owe(cqf_pkg::ST_SHOWN, words[tail], 1'b1);
                end
            end
            default: ; // unused code: no result, no change
        endcase
    endtask

    // Sample both channels and the register port on every rising edge
    always @(posedge i_clk) begin
        cqf_pkg::t_out_item due;
        if (!i_rst_n) begin
            head    = 0;
            tail    = 0;
            drained = 1'b1;
            cap_reg = cqf_pkg::CAP_RESET;
            o_fails = 0;
            answers_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (answers_due.size() == 0) begin
                    report($sformatf("result with nothing owed: status %0d data %0d last %0d",
                                     i_result.status, i_result.data, i_result.last));
                end else begin
                    due = answers_due.pop_front();
                    if (i_result.status !== due.status) begin
                        report($sformatf("status %0d, wanted %0d", i_result.status, due.status));
                    end
                    if (i_result.data !== due.data) begin
                        report($sformatf("data %0d, wanted %0d", i_result.data, due.data));
                    end
                    if (i_result.last !== due.last) begin
                        report($sformatf("last %0d, wanted %0d", i_result.last, due.last));
                    end
                end
            end
            // capacity write empties the queue
            if (i_cfg_we) begin
                cap_reg = i_cfg_data;
                head    = 0;
                tail    = 0;
                drained = 1'b1;
            end
            if (i_push && !i_full) begin
                serve_request(i_item);
            end
        end
        o_pending = answers_due.size();
    end

endmodule

>>> dv/circular_queue_fifo_tb.sv
// Testbench top for the circular queue: clock, reset, request stimulus and verdict.
module circular_queue_fifo_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Action code the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         PHASES     = 6;
    localparam int         PHASE_REQS = 30;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      push       = 1'b0;
    logic                      pop        = 1'b0;
    cqf_pkg::t_in_item         i_item     = '0;
    logic                      i_cfg_we   = 1'b0;
    logic [cqf_pkg::CAP_W-1:0] i_cfg_data = '0;
    logic                      full;
    logic                      empty;
    cqf_pkg::t_out_item        o_result;
    int                        fails;
    int                        pending;
    bit                        calm = 1'b0;

    always #1 i_clk = ~i_clk;

    circular_queue_fifo DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    circular_queue_fifo_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_item     (i_item),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_fails    (fails),
        .o_pending  (pending)
    );

    // Result side: stalls now and then, never during the calm stretch
    always @(negedge i_clk) begin
        pop <= calm || ($urandom_range(99) >= 9);
    end

    // Offer one request, with random gaps, and hold it until taken
    task automatic send(input logic [1:0] act,
                        input logic signed [cqf_pkg::DATA_W-1:0] val);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 9) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_item.action <= act;
        i_item.value  <= val;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
    endtask

    // Stop sending, let every owed result drain, then allow for latency
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [cqf_pkg::CAP_W-1:0] cap);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly random words, with the edge values mixed in
    function automatic logic signed [cqf_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd999;
            3:       return -32'sd1;
            4:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Insert-heavy while filling, delete-heavy while draining
    function automatic logic [1:0] pick_action(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r < (filling ? 70 : 20)) begin
            return cqf_pkg::ACT_INSERT;
        end
        if (r < 80) begin
            return cqf_pkg::ACT_DELETE;
        end
        if (r < 96) begin
            return cqf_pkg::ACT_SHOW;
        end
        return ACT_UNUSED;
    endfunction

    initial begin
        logic [cqf_pkg::CAP_W-1:0] caps [PHASES];
        logic [1:0]                act;
        int                        n;

        caps[0] = 5'd31;
        caps[1] = 5'd2;
        caps[2] = 5'd16;
        caps[3] = 5'd7;
        caps[4] = 5'd1;
        caps[5] = cqf_pkg::CAP_W'($urandom_range(31));

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty queue, extreme words, unused action code, drain back to empty
        send(cqf_pkg::ACT_SHOW, '0);
        send(cqf_pkg::ACT_DELETE, '0);
        send(ACT_UNUSED, 32'sh1234_5678);
        send(cqf_pkg::ACT_INSERT, 32'sh8000_0000);
        send(cqf_pkg::ACT_INSERT, 32'sh7fff_ffff);
        send(cqf_pkg::ACT_INSERT, -32'sd999);
        send(cqf_pkg::ACT_INSERT, -32'sd1);
        send(cqf_pkg::ACT_INSERT, '0);
        send(cqf_pkg::ACT_SHOW, '0);
        send(cqf_pkg::ACT_DELETE, '0);
        send(cqf_pkg::ACT_DELETE, '0);
        send(cqf_pkg::ACT_SHOW, '0);
        send(cqf_pkg::ACT_DELETE, '0);
        send(cqf_pkg::ACT_DELETE, '0);
        send(cqf_pkg::ACT_DELETE, '0);
        send(cqf_pkg::ACT_INSERT, 32'sd5);
        send(cqf_pkg::ACT_SHOW, '0);

        // Capacity zero behaves as a single slot
        set_capacity('0);
        send(cqf_pkg::ACT_INSERT, 32'sh5a5a_5a5a);
        send(cqf_pkg::ACT_INSERT, 32'sd1);
        send(cqf_pkg::ACT_SHOW, '0);
        send(cqf_pkg::ACT_DELETE, '0);
        send(cqf_pkg::ACT_DELETE, '0);

        // Random phases, one capacity each; the third runs with no idling
        for (int ph = 0; ph < PHASES; ph++) begin
            set_capacity(caps[ph]);
            calm <= (ph == 2);
            n = 0;
            while (n < PHASE_REQS) begin
                act = pick_action(n < 20);
                send(act, pick_word());
                if (act != ACT_UNUSED) begin
                    n++;
                    // in the fourth phase, hold off once mid-phase until everything has come back
                    if (ph == 3 && n == PHASE_REQS / 2) begin
                        settle();
                    end
                end
            end
        end
        calm <= 1'b0;

        settle();
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400us;
        $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cqf_pkg.sv
hdl/cqf_fifo.sv
hdl/cqf_front.sv
hdl/cqf_back.sv
hdl/circular_queue_fifo.sv
dv/circular_queue_fifo_checker.sv
dv/circular_queue_fifo_tb.sv
